// File: sv/ctst_pkg.sv
// ----------------------------------------------------------------------------
// ctst_pkg - shared types and constants for the Chebyshev step block
// Queue depths, queue status bundle and packed word widths.
// ----------------------------------------------------------------------------
package ctst_pkg;

	// Depth of the queue between the front and the back part (power of two).
	localparam int MID_DEPTH = 4;
	// Depth of the result queue on the output side (power of two).
	localparam int OUT_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Classified word: arrived, px, py, dx, dy, budget, distance.
	function automatic int item_w(input int cb);
		return 6 * cb + 3;
	endfunction

	// Result word: new_x, new_y, budget_left, arrived.
	function automatic int res_w(input int cb);
		return 3 * cb + 1;
	endfunction

endpackage

// File: sv/ctst_fifo.sv
// ----------------------------------------------------------------------------
// ctst_fifo - small register queue
// Push/pop queue with registered status; depth must be a power of two.
// ----------------------------------------------------------------------------
module ctst_fifo import ctst_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output fifo_stat_t   stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [0:DEPTH-1];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ctst_front.sv
// ----------------------------------------------------------------------------
// ctst_front - input stage
// Accepts items, forms axis differences and Chebyshev distance, classifies
// arrival and hands the word to the middle queue.
// ----------------------------------------------------------------------------
module ctst_front import ctst_pkg::*; #(
	parameter int CB = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [CB-1:0]    pos_x,
	input  logic signed [CB-1:0]    pos_y,
	input  logic signed [CB-1:0]    goal_x,
	input  logic signed [CB-1:0]    goal_y,
	input  logic [CB-1:0]           budget,
	input  fifo_stat_t              mid_stat,
	output logic                    mid_push,
	output logic [item_w(CB)-1:0]   mid_data
);

	typedef struct packed {
		logic                 arr;
		logic [CB-1:0]        px;
		logic [CB-1:0]        py;
		logic signed [CB:0]   dx;
		logic signed [CB:0]   dy;
		logic [CB-1:0]        bud;
		logic [CB-1:0]        dmax;
	} item_t;

	logic signed [CB:0] dx;
	logic signed [CB:0] dy;
	logic [CB:0]        ax;
	logic [CB:0]        ay;
	logic [CB-1:0]      dmax;
	item_t              item_c;
	item_t              item_s1;
	logic               vld_s1;
	logic               take;

	// Differences fit in CB+1 bits; magnitudes fit in CB bits.
	always_comb begin
		dx     = {goal_x[CB-1], goal_x} - {pos_x[CB-1], pos_x};
		dy     = {goal_y[CB-1], goal_y} - {pos_y[CB-1], pos_y};
		ax     = dx[CB] ? -dx : dx;
		ay     = dy[CB] ? -dy : dy;
		dmax   = (ax > ay) ? ax[CB-1:0] : ay[CB-1:0];
		item_c = '{
			arr:  (dmax <= budget),
			px:   pos_x,
			py:   pos_y,
			dx:   dx,
			dy:   dy,
			bud:  budget,
			dmax: dmax
		};
	end

	// Hold the stage while the middle queue is full.
	assign full     = vld_s1 & mid_stat.full;
	assign take     = ~full;
	assign mid_push = vld_s1 & ~mid_stat.full;
	assign mid_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take && push) begin
			item_s1 <= item_c;
		end
	end

endmodule

// File: sv/ctst_back.sv
// ----------------------------------------------------------------------------
// ctst_back - execution pipeline
// Restoring divider (one quotient bit per stage), scale multiply, final
// add; the whole pipeline stalls only when the result queue is full.
// ----------------------------------------------------------------------------
module ctst_back import ctst_pkg::*; #(
	parameter int CB = 24,
	parameter int SB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [item_w(CB)-1:0] mid_data,
	input  fifo_stat_t            mid_stat,
	output logic                  mid_pop,
	input  fifo_stat_t            out_stat,
	output logic                  out_push,
	output logic [res_w(CB)-1:0]  out_data
);

	typedef struct packed {
		logic                 arr;
		logic [CB-1:0]        px;
		logic [CB-1:0]        py;
		logic signed [CB:0]   dx;
		logic signed [CB:0]   dy;
		logic [CB-1:0]        bud;
		logic [CB-1:0]        dmax;
	} item_t;

	logic                      en;
	item_t                     mid_itm;
	logic                      vld_s   [0:SB];
	item_t                     itm_s   [0:SB];
	logic [CB-1:0]             rem_s   [0:SB];
	logic [SB-1:0]             quo_s   [0:SB];
	logic                      vld_m;
	item_t                     itm_m;
	logic signed [CB+SB+1:0]   prx_m;
	logic signed [CB+SB+1:0]   pry_m;
	logic [CB-1:0]             stp_x;
	logic [CB-1:0]             stp_y;
	logic [CB-1:0]             new_x;
	logic [CB-1:0]             new_y;
	logic [CB-1:0]             left;

	// Freeze every stage only when a finished word has nowhere to go.
	assign en      = ~(vld_m & out_stat.full);
	assign mid_pop = en & ~mid_stat.empty;
	assign mid_itm = item_t'(mid_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= ~mid_stat.empty;
		end
	end

	// Remainder starts at the budget, which is below the distance when dividing.
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s[0] <= mid_itm;
			rem_s[0] <= mid_itm.bud;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= SB; k++) begin : g_div
		logic [CB:0] trial;
		logic [CB:0] diff;
		logic        ge;

		assign trial = {rem_s[k-1], 1'b0};
		assign diff  = trial - {1'b0, itm_s[k-1].dmax};
		assign ge    = (trial >= {1'b0, itm_s[k-1].dmax});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k] <= itm_s[k-1];
				rem_s[k] <= ge ? diff[CB-1:0] : trial[CB-1:0];
				quo_s[k] <= {quo_s[k-1][SB-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m <= 1'b0;
		end else if (en) begin
			vld_m <= vld_s[SB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_m <= itm_s[SB];
			prx_m <= $signed(itm_s[SB].dx) * $signed({1'b0, quo_s[SB]});
			pry_m <= $signed(itm_s[SB].dy) * $signed({1'b0, quo_s[SB]});
		end
	end

	// Arrived: step is the full difference, landing on the goal.
	always_comb begin
		stp_x    = itm_m.arr ? itm_m.dx[CB-1:0] : prx_m[SB+CB-1:SB];
		stp_y    = itm_m.arr ? itm_m.dy[CB-1:0] : pry_m[SB+CB-1:SB];
		new_x    = itm_m.px + stp_x;
		new_y    = itm_m.py + stp_y;
		left     = itm_m.arr ? (itm_m.bud - itm_m.dmax) : '0;
		out_data = {new_x, new_y, left, itm_m.arr};
	end

	assign out_push = vld_m & ~out_stat.full;

endmodule

// File: sv/chebyshev_step_toward_target.sv
// ----------------------------------------------------------------------------
// chebyshev_step_toward_target - move a point toward a goal within a budget
// Path: accepted push to empty low runs front, middle queue, divide, multiply, result queue.
// Throughput: one item per cycle unless a full queue stalls; one quotient bit per divide stage.
// Reset: arst_n clears all valid bits and queue pointers; queues come up empty.
// ----------------------------------------------------------------------------
module chebyshev_step_toward_target import ctst_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int SCALE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] goal_x,
	input  logic signed [COORD_BITS-1:0] goal_y,
	input  logic [COORD_BITS-1:0]        budget,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] new_x,
	output logic signed [COORD_BITS-1:0] new_y,
	output logic [COORD_BITS-1:0]        budget_left,
	output logic                         arrived
);

	// Structure:
	//   front  - differences, Chebyshev distance, arrived decision (1 stage)
	//   middle - MID_DEPTH queue that decouples the front from the back
	//   back   - SCALE_BITS restoring-divide stages, one multiply stage,
	//            then the final add that writes the result queue
	//   output - OUT_DEPTH result queue, read with pop/empty
	// Arrived items flow through the divider too; their quotient is ignored
	// and the step becomes the full axis difference.

	localparam int IW  = item_w(COORD_BITS);
	localparam int RW  = res_w(COORD_BITS);
	// Upper bound on words held between the input and output handshakes.
	localparam int CAP = 1 + MID_DEPTH + SCALE_BITS + 2 + OUT_DEPTH;
	localparam int FW  = $clog2(CAP + 1) + 1;

	logic [IW-1:0] f_data;
	logic          f_push;
	logic [IW-1:0] m_data;
	logic          m_pop;
	fifo_stat_t    m_stat;
	logic [RW-1:0] b_data;
	logic          b_push;
	logic [RW-1:0] o_data;
	fifo_stat_t    o_stat;
	logic [FW-1:0] inflight_q;

	ctst_front #(
		.CB (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.goal_x   (goal_x),
		.goal_y   (goal_y),
		.budget   (budget),
		.mid_stat (m_stat),
		.mid_push (f_push),
		.mid_data (f_data)
	);

	ctst_fifo #(
		.W     (IW),
		.DEPTH (MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.pop    (m_pop),
		.rdata  (m_data),
		.stat   (m_stat)
	);

	ctst_back #(
		.CB (COORD_BITS),
		.SB (SCALE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_data (m_data),
		.mid_stat (m_stat),
		.mid_pop  (m_pop),
		.out_stat (o_stat),
		.out_push (b_push),
		.out_data (b_data)
	);

	ctst_fifo #(
		.W     (RW),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  (b_data),
		.pop    (pop),
		.rdata  (o_data),
		.stat   (o_stat)
	);

	// Unpack the head of the result queue.
	assign empty       = o_stat.empty;
	assign new_x       = o_data[RW-1 -: COORD_BITS];
	assign new_y       = o_data[RW-1-COORD_BITS -: COORD_BITS];
	assign budget_left = o_data[COORD_BITS:1];
	assign arrived     = o_data[0];

	// Count words between the two handshakes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if ((push && !full) && !(pop && !empty)) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (!(push && !full) && (pop && !empty)) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// Words are never lost or invented: occupancy stays within capacity.
	a_cap : assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= FW'(CAP))
		else $error("more words in flight than storage");

	// Nothing in flight means nothing to show.
	a_idle : assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> empty)
		else $error("result shown with no word in flight");

	// Full only once the front stage and the middle queue are both occupied.
	a_full : assert property (@(posedge clk) disable iff (!arst_n)
		full |-> inflight_q >= FW'(MID_DEPTH + 1))
		else $error("input stalled with free storage");

	// A partial step spends the whole budget.
	a_left : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !arrived) |-> budget_left == '0)
		else $error("budget left on a partial step");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for chebyshev_step_toward_target
// Drives position/goal/budget words through the push/full side, predicts each
// step in the bench, and checks every popped result word in order. A short
// directed table covers the corners; random words follow under four idling
// phases on the sender and receiver sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB             = 24;
	localparam int SB             = 16;
	// Push-to-result latency of the block.
	localparam int LATENCY        = SB + 4;
	// Cycles without any accepted word before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PER_PHASE = 500;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic [CB-1:0]        span_t;

	typedef struct packed {
		coord_t nx;
		coord_t ny;
		span_t  left;
		logic   arr;
	} step_res_t;

	// One directed row; when typed is set the expected word is taken from res.
	typedef struct packed {
		coord_t    px;
		coord_t    py;
		coord_t    gx;
		coord_t    gy;
		span_t     bud;
		logic      typed;
		step_res_t res;
	} stim_row_t;

	localparam coord_t C_MIN = 24'sh800000;
	localparam coord_t C_MAX = 24'sh7FFFFF;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   push   = 1'b0;
	logic   pop    = 1'b0;
	coord_t pos_x  = '0;
	coord_t pos_y  = '0;
	coord_t goal_x = '0;
	coord_t goal_y = '0;
	span_t  budget = '0;
	logic   full;
	logic   empty;
	coord_t new_x;
	coord_t new_y;
	span_t  budget_left;
	logic   arrived;

	// Expected result words, oldest first.
	step_res_t pending_steps [$];
	int        mismatches  = 0;
	int        idle_cycles = 0;
	int        idle_pct    = 0;
	int        stall_pct   = 0;

	// Corner cases: extremes of every field, zero distance, budget exactly at
	// the distance and one either side, rounding of negative steps, one axis
	// dominating, and tiny scales.
	stim_row_t dir_rows [0:14] = '{
		// everything zero: zero distance with zero budget still arrives
		'{'0, '0, '0, '0, '0, 1'b1, '{'0, '0, '0, 1'b1}},
		// zero distance, full budget is handed back untouched
		'{24'sh123456, -24'sd5, 24'sh123456, -24'sd5, 24'hFFFFFF, 1'b1,
			'{24'sh123456, -24'sd5, 24'hFFFFFF, 1'b1}},
		'{C_MIN, C_MAX, C_MIN, C_MAX, '0, 1'b1, '{C_MIN, C_MAX, '0, 1'b1}},
		// longest x span with no budget: scale is zero, stay put
		'{C_MAX, '0, C_MIN, '0, '0, 1'b1, '{C_MAX, '0, '0, 1'b0}},
		// longest diagonal with exactly enough budget
		'{C_MIN, C_MIN, C_MAX, C_MAX, 24'hFFFFFF, 1'b1, '{C_MAX, C_MAX, '0, 1'b1}},
		// one short of it: largest scale below one
		'{C_MIN, C_MIN, C_MAX, C_MAX, 24'hFFFFFE, 1'b0, '0},
		// budget equal to distance, then one above, then one below
		'{'0, '0, 24'sh100, -24'sh80, 24'h100, 1'b1, '{24'sh100, -24'sh80, '0, 1'b1}},
		'{'0, '0, 24'sh100, -24'sh80, 24'h101, 1'b1, '{24'sh100, -24'sh80, 24'h1, 1'b1}},
		'{'0, '0, 24'sh100, -24'sh80, 24'h0FF, 1'b0, '0},
		// exact half step in the negative direction
		'{24'sh1000, 24'sh1000, '0, '0, 24'h800, 1'b1, '{24'sh800, 24'sh800, '0, 1'b0}},
		// negative partial step rounds toward minus infinity
		'{'0, '0, -24'sd3, 24'sd1, 24'h1, 1'b0, '0},
		// y axis dominates
		'{-24'sh200, 24'sh7FFF00, 24'sh100, -24'sh7FFF00, 24'h012345, 1'b0, '0},
		// tiny scale over the full range
		'{C_MAX, C_MIN, C_MIN, C_MAX, 24'h1, 1'b0, '0},
		'{-24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'h1, 1'b0, '0},
		'{24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA, 24'h5A5A5A, 1'b0, '0}
	};

	chebyshev_step_toward_target #(
		.COORD_BITS(CB),
		.SCALE_BITS(SB)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.goal_x     (goal_x),
		.goal_y     (goal_y),
		.budget     (budget),
		.empty      (empty),
		.pop        (pop),
		.new_x      (new_x),
		.new_y      (new_y),
		.budget_left(budget_left),
		.arrived    (arrived)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Chebyshev distance at full width, so it never wraps.
	function automatic longint cheb_span(input coord_t px, py, gx, gy);
		longint dx, dy;
		dx = longint'(gx) - longint'(px);
		dy = longint'(gy) - longint'(py);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx > dy) ? dx : dy;
	endfunction

	// Predict one step: land on the goal if the budget covers the distance,
	// else scale both differences by floor(budget * 2^SB / distance) and shift right by SB.
	function automatic step_res_t step_toward(input coord_t px, py, gx, gy, input span_t bud);
		step_res_t r;
		longint    span;
		longint    scale;
		longint    mx, my;
		span = cheb_span(px, py, gx, gy);
		if (span <= longint'(bud)) begin
			r.nx   = gx;
			r.ny   = gy;
			r.left = span_t'(longint'(bud) - span);
			r.arr  = 1'b1;
		end else begin
			scale = (longint'(bud) << SB) / span;
			// Arithmetic shift of a signed product floors toward minus infinity.
			mx    = longint'(px) + (((longint'(gx) - longint'(px)) * scale) >>> SB);
			my    = longint'(py) + (((longint'(gy) - longint'(py)) * scale) >>> SB);
			r.nx  = mx[CB-1:0];
			r.ny  = my[CB-1:0];
			r.left = '0;
			r.arr  = 1'b0;
		end
		return r;
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(5))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return -24'sd1;
			4: return 24'sd1;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Random word, mostly shaped so both the arrive and the partial-step paths
	// see small, exact-boundary and extreme cases, with plain noise mixed in.
	task automatic random_word(output coord_t px, py, gx, gy, output span_t bud);
		longint span;
		px  = coord_t'($urandom);
		py  = coord_t'($urandom);
		gx  = coord_t'($urandom);
		gy  = coord_t'($urandom);
		bud = span_t'($urandom);
		case ($urandom_range(9))
			3, 4: begin
				// short hop with a small budget
				gx  = coord_t'(px + $urandom_range(2047) - 1024);
				gy  = coord_t'(py + $urandom_range(2047) - 1024);
				bud = span_t'($urandom_range(2047));
			end
			5: begin
				gx = px;
				gy = py;
			end
			6: begin
				// budget at the distance or one either side
				gx   = coord_t'(px + $urandom_range(65535) - 32768);
				gy   = coord_t'(py + $urandom_range(65535) - 32768);
				span = cheb_span(px, py, gx, gy);
				bud  = span_t'(span + $urandom_range(2) - 1);
			end
			7: bud = $urandom_range(1) ? '1 : '0;
			8: begin
				px = pick_extreme();
				py = pick_extreme();
				gx = pick_extreme();
				gy = pick_extreme();
			end
			9: begin
				// one axis nearly still, the other carries the distance
				if ($urandom_range(1))
					gy = coord_t'(py + $urandom_range(31) - 16);
				else
					gx = coord_t'(px + $urandom_range(31) - 16);
			end
			default: ;
		endcase
	endtask

	// Offer one word, idling first as the phase asks; hold push and the fields
	// until full is seen low at an edge, then queue the expected result.
	task automatic send_word(input coord_t px, py, gx, gy, input span_t bud,
			input logic typed, input step_res_t typed_res);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		pos_x  <= px;
		pos_y  <= py;
		goal_x <= gx;
		goal_y <= gy;
		budget <= bud;
		do @(posedge clk); while (full);
		pending_steps.push_back(typed ? typed_res : step_toward(px, py, gx, gy, bud));
	endtask

	// Receiver side: stall pop at random, check each popped word against the
	// oldest expectation, and watch for a hang.
	always @(posedge clk) begin : result_check
		step_res_t want;
		pop <= ($urandom_range(99) >= stall_pct);
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_steps.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word x=%h y=%h left=%h arrived=%b",
						$time, new_x, new_y, budget_left, arrived);
				end else begin
					want = pending_steps.pop_front();
					if (new_x !== want.nx) begin
						mismatches++;
						$display("%0t: new_x expected %h got %h", $time, want.nx, new_x);
					end
					if (new_y !== want.ny) begin
						mismatches++;
						$display("%0t: new_y expected %h got %h", $time, want.ny, new_y);
					end
					if (budget_left !== want.left) begin
						mismatches++;
						$display("%0t: budget_left expected %h got %h",
							$time, want.left, budget_left);
					end
					if (arrived !== want.arr) begin
						mismatches++;
						$display("%0t: arrived expected %b got %b", $time, want.arr, arrived);
					end
				end
			end
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		coord_t px, py, gx, gy;
		span_t  bud;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners run with no idling on either side.
		foreach (dir_rows[i])
			send_word(dir_rows[i].px, dir_rows[i].py, dir_rows[i].gx, dir_rows[i].gy,
				dir_rows[i].bud, dir_rows[i].typed, dir_rows[i].res);

		// Random words: no idling, sender idling, receiver stalling, then both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				random_word(px, py, gx, gy, bud);
				send_word(px, py, gx, gy, bud, 1'b0, '0);
			end
		end

		// Drain: stop pushing, pop freely, then allow time for a stray word.
		push      <= 1'b0;
		stall_pct = 0;
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
